FILE: rtl/fpt_pkg.sv
// package with shared constants for the fermat primality test block
package fpt_pkg;

    localparam int CAND_W             = 62;
    localparam int RAND_W             = 31;
    localparam int NUM_RANDOM         = 5;
    localparam int ROUNDS_W           = 3;
    localparam int WITNESS_W          = 3;
    localparam int ROUNDS_RESET       = 5;
    localparam int MAX_ROUNDS_DEF     = 5;
    localparam int CANDIDATE_BITS_DEF = 62;

    localparam int DIRECT_LIMIT = 4;
    localparam int PRIME_TWO    = 2;
    localparam int PRIME_THREE  = 3;
    localparam int BASE_OFFSET  = 2;

    localparam int IN_FIELDS_W = CAND_W + NUM_RANDOM * RAND_W;
    localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = 1 + WITNESS_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

endpackage

FILE: rtl/fpt_modred.sv
// bit-serial restoring remainder unit for the random word modulo a divisor
module fpt_modred
    import fpt_pkg::*;
#(
    parameter int W = CANDIDATE_BITS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [RAND_W-1:0] r,
    input  logic [W-1:0]      d,
    output logic              done,
    output logic [W-1:0]      rem
);

    localparam int CNT_W = $clog2(RAND_W + 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [W-1:0]      rem_reg, rem_next;
    logic [RAND_W-1:0] r_reg, r_next;
    logic [W-1:0]      d_reg, d_next;
    logic [W:0]        trial;
    logic [W:0]        diff;

    assign trial = {rem_reg, r_reg[RAND_W-1]};
    assign diff  = trial - {1'b0, d_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(RAND_W);
            rem_next  = '0;
            r_next    = r;
            d_next    = d;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - CNT_W'(1);
                rem_next = diff[W] ? trial[W-1:0] : diff[W-1:0];
                r_next   = r_reg << 1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        r_reg   <= r_next;
        d_reg   <= d_next;
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

FILE: rtl/fpt_modmul.sv
// shift-and-add modular multiplier, one multiplier bit per cycle
module fpt_modmul
    import fpt_pkg::*;
#(
    parameter int W = CANDIDATE_BITS_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] a,
    input  logic [W-1:0] b,
    input  logic [W-1:0] m,
    output logic         done,
    output logic [W-1:0] result
);

    logic         busy_reg, busy_next;
    logic         done_reg, done_next;
    logic [W-1:0] acc_reg, acc_next;
    logic [W-1:0] dbl_reg, dbl_next;
    logic [W-1:0] b_reg, b_next;
    logic [W-1:0] m_reg, m_next;
    logic [W:0]   sum;
    logic [W:0]   sum_diff;
    logic [W:0]   twice;
    logic [W:0]   twice_diff;

    // both sums stay below 2m, so one conditional subtract reduces them
    assign sum        = {1'b0, acc_reg} + {1'b0, dbl_reg};
    assign sum_diff   = sum - {1'b0, m_reg};
    assign twice      = {dbl_reg, 1'b0};
    assign twice_diff = twice - {1'b0, m_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        acc_next  = acc_reg;
        dbl_next  = dbl_reg;
        b_next    = b_reg;
        m_next    = m_reg;
        if (start)
        begin
            busy_next = 1'b1;
            acc_next  = '0;
            dbl_next  = a;
            b_next    = b;
            m_next    = m;
        end
        else if (busy_reg)
        begin
            if (b_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                if (b_reg[0])
                begin
                    acc_next = sum_diff[W] ? sum[W-1:0] : sum_diff[W-1:0];
                end
                dbl_next = twice_diff[W] ? twice[W-1:0] : twice_diff[W-1:0];
                b_next   = b_reg >> 1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        dbl_reg <= dbl_next;
        b_reg   <= b_next;
        m_reg   <= m_next;
    end

    assign done   = done_reg;
    assign result = acc_reg;

endmodule

FILE: rtl/fermat_primality_test.sv
// top level of the fermat primality test with round sequencer and stream ports
// candidates below 4 skip the rounds and go from S_IDLE through S_OUT to the output register
// larger candidates: per round one base reduction, then per exponent bit one
// sequencer step, one multiply for a set bit and one squaring, which is skipped
// after the top exponent bit
// one item at a time; reset sets rounds_in_use to 5 and clears all control state
module fermat_primality_test
    import fpt_pkg::*;
#(
    parameter int MAX_ROUNDS     = MAX_ROUNDS_DEF,
    parameter int CANDIDATE_BITS = CANDIDATE_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [ROUNDS_W-1:0]    cfg_data,      // rounds_in_use
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // candidate, random_0 .. random_4
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata   // is_probable_prime, witness_round
);

    localparam int W       = CANDIDATE_BITS;
    localparam int ROUND_W = $clog2(MAX_ROUNDS + 1);
    localparam int RIDX_W  = $clog2(NUM_RANDOM);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RED,
        S_BIT,
        S_MA,
        S_SQ,
        S_OUT
    } state_t;

    state_t               state_reg, state_next;
    logic [ROUNDS_W-1:0]  rounds_in_use_reg;
    logic                 mm_start_reg, mm_start_next;
    logic                 red_start_reg, red_start_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 out_prime_reg, out_prime_next;
    logic [WITNESS_W-1:0] out_wit_reg, out_wit_next;
    logic [ROUND_W-1:0]   round_reg, round_next;
    logic [RIDX_W-1:0]    ridx_reg, ridx_next;
    logic [ROUND_W-1:0]   lim_reg, lim_next;

    logic [W-1:0]         n_reg, n_next;
    logic [RAND_W-1:0]    rand_reg [NUM_RANDOM];
    logic [RAND_W-1:0]    rand_next [NUM_RANDOM];
    logic [W-1:0]         base_reg, base_next;
    logic [W-1:0]         acc_reg, acc_next;
    logic [W-1:0]         e_reg, e_next;
    logic                 res_prime_reg, res_prime_next;
    logic [WITNESS_W-1:0] res_wit_reg, res_wit_next;

    logic                 in_accept;
    logic [W-1:0]         n_in;
    logic [ROUND_W-1:0]   lim_cfg;
    logic [ROUND_W:0]     round_inc;
    logic [7:0]           wit_ext;
    logic [W-1:0]         mm_a;
    logic                 mm_done;
    logic [W-1:0]         mm_result;
    logic                 red_done;
    logic [W-1:0]         red_rem;

    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE);
    assign cfg_ready     = 1'b1;
    assign n_in          = s_axis_tdata[W-1:0];
    assign round_inc     = {1'b0, round_reg} + (ROUND_W + 1)'(1);
    assign wit_ext       = 8'(round_reg) + 8'd1;
    assign mm_a          = (state_reg == S_SQ) ? base_reg : acc_reg;

    always_comb
    begin
        if (rounds_in_use_reg == '0)
        begin
            lim_cfg = ROUND_W'(1);
        end
        else if (int'(rounds_in_use_reg) > MAX_ROUNDS)
        begin
            lim_cfg = ROUND_W'(MAX_ROUNDS);
        end
        else
        begin
            lim_cfg = ROUND_W'(rounds_in_use_reg);
        end
    end

    fpt_modred #(
        .W(W)
    ) u_modred (
        .clk   (clk),
        .rst_n (rst_n),
        .start (red_start_reg),
        .r     (rand_reg[ridx_reg]),
        .d     (n_reg - W'(PRIME_THREE)),
        .done  (red_done),
        .rem   (red_rem)
    );

    fpt_modmul #(
        .W(W)
    ) u_modmul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mm_start_reg),
        .a      (mm_a),
        .b      (base_reg),
        .m      (n_reg),
        .done   (mm_done),
        .result (mm_result)
    );

    always_comb
    begin
        state_next     = state_reg;
        mm_start_next  = 1'b0;
        red_start_next = 1'b0;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_prime_next = out_prime_reg;
        out_wit_next   = out_wit_reg;
        round_next     = round_reg;
        ridx_next      = ridx_reg;
        lim_next       = lim_reg;
        n_next         = n_reg;
        rand_next      = rand_reg;
        base_next      = base_reg;
        acc_next       = acc_reg;
        e_next         = e_reg;
        res_prime_next = res_prime_reg;
        res_wit_next   = res_wit_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    n_next     = n_in;
                    for (int i = 0; i < NUM_RANDOM; i++)
                    begin
                        rand_next[i] = s_axis_tdata[CAND_W + i * RAND_W +: RAND_W];
                    end
                    lim_next   = lim_cfg;
                    round_next = '0;
                    ridx_next  = '0;
                    if (n_in < W'(DIRECT_LIMIT))
                    begin
                        res_prime_next = (n_in == W'(PRIME_TWO)) || (n_in == W'(PRIME_THREE));
                        res_wit_next   = '0;
                        state_next     = S_OUT;
                    end
                    else
                    begin
                        red_start_next = 1'b1;
                        state_next     = S_RED;
                    end
                end
            end
            S_RED:
            begin
                if (red_done)
                begin
                    base_next  = red_rem + W'(BASE_OFFSET);
                    acc_next   = W'(1);
                    e_next     = n_reg - W'(1);
                    state_next = S_BIT;
                end
            end
            S_BIT:
            begin
                if (e_reg == '0)
                begin
                    if (acc_reg != W'(1))
                    begin
                        res_prime_next = 1'b0;
                        res_wit_next   = wit_ext[WITNESS_W-1:0];
                        state_next     = S_OUT;
                    end
                    else if (round_inc == {1'b0, lim_reg})
                    begin
                        res_prime_next = 1'b1;
                        res_wit_next   = '0;
                        state_next     = S_OUT;
                    end
                    else
                    begin
                        round_next     = round_inc[ROUND_W-1:0];
                        ridx_next      = (ridx_reg == RIDX_W'(NUM_RANDOM - 1)) ? '0
                                         : ridx_reg + RIDX_W'(1);
                        red_start_next = 1'b1;
                        state_next     = S_RED;
                    end
                end
                else if (e_reg[0])
                begin
                    mm_start_next = 1'b1;
                    state_next    = S_MA;
                end
                else
                begin
                    e_next        = e_reg >> 1;
                    mm_start_next = 1'b1;
                    state_next    = S_SQ;
                end
            end
            S_MA:
            begin
                if (mm_done)
                begin
                    acc_next = mm_result;
                    e_next   = e_reg >> 1;
                    // skip the squaring after the top exponent bit
                    if (e_reg[W-1:1] != '0)
                    begin
                        mm_start_next = 1'b1;
                        state_next    = S_SQ;
                    end
                    else
                    begin
                        state_next = S_BIT;
                    end
                end
            end
            S_SQ:
            begin
                if (mm_done)
                begin
                    base_next  = mm_result;
                    state_next = S_BIT;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_prime_next = res_prime_reg;
                    out_wit_next   = res_wit_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            rounds_in_use_reg <= ROUNDS_W'(ROUNDS_RESET);
            mm_start_reg      <= 1'b0;
            red_start_reg     <= 1'b0;
            out_valid_reg     <= 1'b0;
            out_prime_reg     <= 1'b0;
            out_wit_reg       <= '0;
            round_reg         <= '0;
            ridx_reg          <= '0;
            lim_reg           <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                rounds_in_use_reg <= cfg_data;
            end
            mm_start_reg  <= mm_start_next;
            red_start_reg <= red_start_next;
            out_valid_reg <= out_valid_next;
            out_prime_reg <= out_prime_next;
            out_wit_reg   <= out_wit_next;
            round_reg     <= round_next;
            ridx_reg      <= ridx_next;
            lim_reg       <= lim_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg         <= n_next;
        rand_reg      <= rand_next;
        base_reg      <= base_next;
        acc_reg       <= acc_next;
        e_reg         <= e_next;
        res_prime_reg <= res_prime_next;
        res_wit_reg   <= res_wit_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_W - OUT_FIELDS_W){1'b0}}, out_wit_reg, out_prime_reg};

    // a reported witness always means composite
    a_witness_composite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_prime_reg && out_wit_reg != '0))
        else $error("witness round reported for a probable prime");

    // multiplier results only arrive while the sequencer waits for them
    a_mm_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        mm_done |-> (state_reg == S_MA || state_reg == S_SQ))
        else $error("multiplier done outside a multiply state");

    // an accepted item makes the block busy on the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> !s_axis_tready)
        else $error("input still ready after a transaction");

    // the round counter never passes the round limit
    a_round_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_BIT || state_reg == S_RED) |-> (round_reg < lim_reg))
        else $error("round counter beyond round limit");

endmodule
